FILE: src/jhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jhs_pkg;

  localparam logic [7:0] BYTE_FILL   = 8'hFF;
  localparam logic [7:0] BYTE_SOI    = 8'hD8;
  localparam logic [7:0] BYTE_SOS    = 8'hDA;
  localparam logic [7:0] BYTE_EOI    = 8'hD9;
  localparam logic [3:0] SOF_GROUP   = 4'hC;
  localparam logic [7:0] BYTE_DHT    = 8'hC4;
  localparam logic [7:0] BYTE_JPG    = 8'hC8;
  localparam logic [7:0] BYTE_DAC    = 8'hCC;
  localparam logic [15:0] LEN_MIN    = 16'd2;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NO_SOI    = 3'd1;
  localparam logic [2:0] ST_STRAY     = 3'd2;
  localparam logic [2:0] ST_NO_FRAME  = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;

  localparam logic [3:0] PH_START0  = 4'd0;
  localparam logic [3:0] PH_START1  = 4'd1;
  localparam logic [3:0] PH_SEEK    = 4'd2;
  localparam logic [3:0] PH_FILL    = 4'd3;
  localparam logic [3:0] PH_LEN_HI  = 4'd4;
  localparam logic [3:0] PH_LEN_LO  = 4'd5;
  localparam logic [3:0] PH_SKIP    = 4'd6;
  localparam logic [3:0] PH_FLEN_HI = 4'd7;
  localparam logic [3:0] PH_FLEN_LO = 4'd8;
  localparam logic [3:0] PH_PREC    = 4'd9;
  localparam logic [3:0] PH_H_HI    = 4'd10;
  localparam logic [3:0] PH_H_LO    = 4'd11;
  localparam logic [3:0] PH_W_HI    = 4'd12;
  localparam logic [3:0] PH_W_LO    = 4'd13;
  localparam logic [3:0] PH_NCOMP   = 4'd14;

  typedef struct packed {
    logic        have;
    logic [2:0]  status;
    logic [15:0] height;
    logic [15:0] width;
  } res_t;

  function automatic logic is_frame_marker(input logic [7:0] c);
    return (c[7:4] == SOF_GROUP) && (c != BYTE_DHT) && (c != BYTE_JPG) && (c != BYTE_DAC);
  endfunction

endpackage

`default_nettype wire

FILE: src/jpeg_header_size_scan.sv
// A byte accepted into the input register is parsed combinationally; its result is registered on the outputs.
// Throughput: one byte per cycle while the result is not stalled; the parser state updates in a single step
// between the input register and the result register.
// A stalled result stalls the input whenever the input register holds a byte.
// Reset (rst, synchronous): parser idle until a beat with first_byte set.
`timescale 1ns / 1ps
`default_nettype none

module jpeg_header_size_scan import jhs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       scan_status,
  output logic [15:0]      frame_height,
  output logic [15:0]      frame_width
);

  logic       r_valid;
  logic [7:0] r_data;
  logic       r_first;
  logic       r_last;
  logic       out_free;
  logic       step;
  res_t       res;

  assign out_free = !out_valid || !out_stall;
  assign step     = r_valid && out_free;
  assign in_stall = r_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (!in_stall) begin
      r_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      r_data  <= data_byte;
      r_first <= first_byte;
      r_last  <= last_byte;
    end
  end

  jhs_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (r_data),
    .first_byte (r_first),
    .last_byte  (r_last),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res.have;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      scan_status  <= res.status;
      frame_height <= res.height;
      frame_width  <= res.width;
    end
  end

endmodule

`default_nettype wire

FILE: src/jhs_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module jhs_parse import jhs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_byte,
  input  wire logic       last_byte,
  output res_t            res
);

  logic [3:0]  phase, phase_next;
  logic [15:0] skip_count, skip_count_next;
  logic [7:0]  upper_byte, upper_byte_next;
  logic        stray_seen, stray_seen_next;
  logic [15:0] held_height, held_height_next;
  logic [15:0] held_width, held_width_next;
  logic        finished, finished_next;

  logic        active;
  logic        have;
  logic [2:0]  st;
  logic [15:0] len;
  logic [15:0] skip_dec;

  always_comb begin
    active = first_byte || !finished;
    if (first_byte) begin
      phase_next       = PH_START0;
      skip_count_next  = '0;
      upper_byte_next  = '0;
      stray_seen_next  = 1'b0;
      held_height_next = '0;
      held_width_next  = '0;
    end else begin
      phase_next       = phase;
      skip_count_next  = skip_count;
      upper_byte_next  = upper_byte;
      stray_seen_next  = stray_seen;
      held_height_next = held_height;
      held_width_next  = held_width;
    end
    len      = {upper_byte_next, data_byte};
    skip_dec = skip_count_next - 16'd1;
    have     = 1'b0;
    st       = ST_FOUND;

    unique case (phase_next)
      PH_START0: begin
        if (data_byte == BYTE_FILL) phase_next = PH_START1;
        else begin
          have = 1'b1;
          st   = ST_NO_SOI;
        end
      end
      PH_START1: begin
        if (data_byte == BYTE_SOI) begin
          phase_next      = PH_SEEK;
          stray_seen_next = 1'b0;
        end else begin
          have = 1'b1;
          st   = ST_NO_SOI;
        end
      end
      PH_SEEK: begin
        if (data_byte == BYTE_FILL) phase_next = PH_FILL;
        else stray_seen_next = 1'b1;
      end
      PH_FILL: begin
        if (data_byte != BYTE_FILL) begin
          priority if (stray_seen_next) begin
            have = 1'b1;
            st   = ST_STRAY;
          end else if (is_frame_marker(data_byte)) begin
            phase_next = PH_FLEN_HI;
          end else if (data_byte == BYTE_SOS || data_byte == BYTE_EOI) begin
            have = 1'b1;
            st   = ST_NO_FRAME;
          end else begin
            phase_next = PH_LEN_HI;
          end
          stray_seen_next = 1'b0;
        end
      end
      PH_LEN_HI: begin
        upper_byte_next = data_byte;
        phase_next      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        priority if (len < LEN_MIN) begin
          have = 1'b1;
          st   = ST_BAD_LEN;
        end else if (len == LEN_MIN) begin
          phase_next      = PH_SEEK;
          stray_seen_next = 1'b0;
        end else begin
          skip_count_next = len - LEN_MIN;
          phase_next      = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next      = PH_SEEK;
          stray_seen_next = 1'b0;
        end
      end
      PH_FLEN_HI: phase_next = PH_FLEN_LO;
      PH_FLEN_LO: phase_next = PH_PREC;
      PH_PREC:    phase_next = PH_H_HI;
      PH_H_HI: begin
        upper_byte_next = data_byte;
        phase_next      = PH_H_LO;
      end
      PH_H_LO: begin
        held_height_next = {upper_byte_next, data_byte};
        phase_next       = PH_W_HI;
      end
      PH_W_HI: begin
        upper_byte_next = data_byte;
        phase_next      = PH_W_LO;
      end
      PH_W_LO: begin
        held_width_next = {upper_byte_next, data_byte};
        phase_next      = PH_NCOMP;
      end
      PH_NCOMP: begin
        have = 1'b1;
        st   = ST_FOUND;
      end
      default: begin
        have = 1'b1;
        st   = ST_TRUNCATED;
      end
    endcase

    if (!have && last_byte) begin
      have = 1'b1;
      st   = (phase_next <= PH_START1) ? ST_NO_SOI : ST_TRUNCATED;
    end

    if (!active) have = 1'b0;
    finished_next = have ? 1'b1 : (first_byte ? 1'b0 : finished);

    res.have   = have;
    res.status = st;
    res.height = (st == ST_FOUND) ? held_height_next : '0;
    res.width  = (st == ST_FOUND) ? held_width_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START0;
      skip_count  <= '0;
      upper_byte  <= '0;
      stray_seen  <= 1'b0;
      held_height <= '0;
      held_width  <= '0;
      finished    <= 1'b1;
    end else if (step && active) begin
      phase       <= phase_next;
      skip_count  <= skip_count_next;
      upper_byte  <= upper_byte_next;
      stray_seen  <= stray_seen_next;
      held_height <= held_height_next;
      held_width  <= held_width_next;
      finished    <= finished_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/jhs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module jhs_checker import jhs_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  scan_status,
  input wire logic [15:0] frame_height,
  input wire logic [15:0] frame_width
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(scan_status) && $stable(frame_height)
      && $stable(frame_width))
    else $error("stalled result beat changed");

  a_size_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && scan_status != ST_FOUND |-> frame_height == '0 && frame_width == '0)
    else $error("size reported with error status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> scan_status <= ST_TRUNCATED)
    else $error("status code out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

endmodule

bind jpeg_header_size_scan jhs_checker u_jhs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .scan_status  (scan_status),
  .frame_height (frame_height),
  .frame_width  (frame_width)
);

`default_nettype wire

FILE: tb/tb_jpeg_header_size_scan.sv
`timescale 1ns / 1ps

module tb_jpeg_header_size_scan import jhs_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned BEAT_TARGET = 950;
  localparam int unsigned QUIET_FROM  = 800;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_kind_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] height;
    logic [15:0] width;
  } size_result_t;

  typedef struct packed {
    logic [7:0] d;
    logic       f;
    logic       l;
  } beat_t;

  typedef struct {
    beat_t        b;
    row_kind_t    kind;
    size_result_t res;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  scan_status;
  logic [15:0] frame_height;
  logic [15:0] frame_width;

  logic        gaps_on = 1'b1;
  logic [3:0]  stall_left = 4'd0;
  int unsigned cycle_count = 0;
  int unsigned sent_beats = 0;
  int          fail_count = 0;

  size_result_t expected_sizes[$];
  stim_row_t    dir_rows[$];
  beat_t        file_bytes[$];

  logic [3:0]  scan_phase;
  logic [15:0] bytes_left;
  logic [7:0]  hi_byte;
  logic        stray_flag;
  logic [15:0] hold_h;
  logic [15:0] hold_w;
  logic        scan_done;

  jpeg_header_size_scan u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .scan_status (scan_status),
    .frame_height(frame_height),
    .frame_width (frame_width)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic is_sof_code(input logic [7:0] c);
    return c[7:4] == SOF_GROUP && c != BYTE_DHT && c != BYTE_JPG && c != BYTE_DAC;
  endfunction

  function automatic void step_size_scan(input logic [7:0] d, input logic f, input logic l,
                                         output logic have, output size_result_t r);
    logic [15:0] seg_len;
    logic [2:0]  st;
    have = 1'b0;
    st   = ST_FOUND;
    r    = '0;
    if (f) begin
      scan_phase = PH_START0;
      bytes_left = '0;
      hi_byte    = '0;
      stray_flag = 1'b0;
      hold_h     = '0;
      hold_w     = '0;
      scan_done  = 1'b0;
    end else if (scan_done) begin
      return;
    end
    case (scan_phase)
      PH_START0: begin
        if (d == BYTE_FILL) scan_phase = PH_START1;
        else begin have = 1'b1; st = ST_NO_SOI; end
      end
      PH_START1: begin
        if (d == BYTE_SOI) begin scan_phase = PH_SEEK; stray_flag = 1'b0; end
        else begin have = 1'b1; st = ST_NO_SOI; end
      end
      PH_SEEK: begin
        if (d == BYTE_FILL) scan_phase = PH_FILL;
        else stray_flag = 1'b1;
      end
      PH_FILL: begin
        if (d != BYTE_FILL) begin
          if (stray_flag) begin have = 1'b1; st = ST_STRAY; end
          else if (is_sof_code(d)) scan_phase = PH_FLEN_HI;
          else if (d == BYTE_SOS || d == BYTE_EOI) begin have = 1'b1; st = ST_NO_FRAME; end
          else scan_phase = PH_LEN_HI;
          stray_flag = 1'b0;
        end
      end
      PH_LEN_HI: begin hi_byte = d; scan_phase = PH_LEN_LO; end
      PH_LEN_LO: begin
        seg_len = {hi_byte, d};
        if (seg_len < LEN_MIN) begin have = 1'b1; st = ST_BAD_LEN; end
        else if (seg_len == LEN_MIN) begin scan_phase = PH_SEEK; stray_flag = 1'b0; end
        else begin bytes_left = seg_len - LEN_MIN; scan_phase = PH_SKIP; end
      end
      PH_SKIP: begin
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) begin scan_phase = PH_SEEK; stray_flag = 1'b0; end
      end
      PH_FLEN_HI: scan_phase = PH_FLEN_LO;
      PH_FLEN_LO: scan_phase = PH_PREC;
      PH_PREC:    scan_phase = PH_H_HI;
      PH_H_HI:    begin hi_byte = d; scan_phase = PH_H_LO; end
      PH_H_LO:    begin hold_h = {hi_byte, d}; scan_phase = PH_W_HI; end
      PH_W_HI:    begin hi_byte = d; scan_phase = PH_W_LO; end
      PH_W_LO:    begin hold_w = {hi_byte, d}; scan_phase = PH_NCOMP; end
      PH_NCOMP:   begin have = 1'b1; st = ST_FOUND; end
      default:    begin have = 1'b1; st = ST_TRUNCATED; end
    endcase
    if (!have && l) begin
      have = 1'b1;
      st = (scan_phase <= PH_START1) ? ST_NO_SOI : ST_TRUNCATED;
    end
    if (have) begin
      scan_done = 1'b1;
      r.status  = st;
      r.height  = (st == ST_FOUND) ? hold_h : 16'd0;
      r.width   = (st == ST_FOUND) ? hold_w : 16'd0;
    end
  endfunction

  task automatic push_beat(input beat_t b, input row_kind_t kind, input size_result_t typed);
    logic         have;
    size_result_t r;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b.d;
    first_byte <= b.f;
    last_byte  <= b.l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_size_scan(b.d, b.f, b.l, have, r);
    sent_beats++;
    if (kind == ROW_RESULT) expected_sizes.push_back(typed);
    else if (kind == ROW_PREDICT && have) expected_sizes.push_back(r);
  endtask

  function automatic void add_row(input logic [7:0] d, input logic f, input logic l,
                                  input row_kind_t kind, input logic [2:0] st,
                                  input logic [15:0] h, input logic [15:0] w);
    stim_row_t row;
    row.b    = {d, f, l};
    row.kind = kind;
    row.res  = {st, h, w};
    dir_rows.push_back(row);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    file_bytes.push_back({b, 2'b00});
  endfunction

  function automatic logic [15:0] pick_size();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic build_random_file();
    int unsigned sel;
    int unsigned nseg;
    int unsigned seg_len;
    int unsigned keep;
    logic [7:0]  m;
    logic [15:0] sz;
    file_bytes.delete();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      put_byte(BYTE_FILL);
      put_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : BYTE_SOI);
      nseg = $urandom_range(0, 3);
      for (int i = 0; i < nseg; i++) begin
        if ($urandom_range(0, 11) == 0)
          repeat ($urandom_range(1, 2)) put_byte(8'($urandom_range(0, 254)));
        put_byte(BYTE_FILL);
        repeat ($urandom_range(0, 3) / 2) put_byte(BYTE_FILL);
        do m = 8'($urandom_range(0, 255));
        while (m == BYTE_FILL || m == BYTE_SOS || m == BYTE_EOI || is_sof_code(m));
        put_byte(m);
        sel = $urandom_range(0, 99);
        if (sel < 4) seg_len = $urandom_range(0, 1);
        else if (sel < 7) seg_len = $urandom_range(200, 600);
        else seg_len = $urandom_range(2, 10);
        put_byte(8'(seg_len >> 8));
        put_byte(8'(seg_len));
        if (seg_len >= 2)
          repeat (seg_len - 2) put_byte(8'($urandom_range(0, 255)));
      end
      put_byte(BYTE_FILL);
      if ($urandom_range(0, 99) < 10) begin
        put_byte(($urandom_range(0, 1) == 0) ? BYTE_SOS : BYTE_EOI);
      end else begin
        do m = {SOF_GROUP, 4'($urandom_range(0, 15))};
        while (!is_sof_code(m));
        put_byte(m);
        repeat (3) put_byte(8'($urandom_range(0, 255)));
        sz = pick_size();
        put_byte(sz[15:8]);
        put_byte(sz[7:0]);
        sz = pick_size();
        put_byte(sz[15:8]);
        put_byte(sz[7:0]);
        put_byte(8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 5)
        file_bytes[$urandom_range(0, file_bytes.size() - 1)].d = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 15) begin
        keep = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end
    end
    file_bytes[0].f = 1'b1;
    sel = $urandom_range(0, 99);
    if (sel < 60) file_bytes[file_bytes.size() - 1].l = 1'b1;
    else if (sel < 70) file_bytes[$urandom_range(0, file_bytes.size() - 1)].l = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 4'd0;
    end else if (stall_left != 4'd0) begin
      stall_left <= stall_left - 4'd1;
      out_stall  <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= 4'($urandom_range(0, 8));
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    size_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sizes.size() == 0) begin
        $error("result with none expected: scan_status %0d", scan_status);
        fail_count++;
      end else begin
        want = expected_sizes.pop_front();
        if (scan_status !== want.status) begin
          $error("scan_status: expected %0d, actual %0d", want.status, scan_status);
          fail_count++;
        end
        if (frame_height !== want.height) begin
          $error("frame_height: expected %0d, actual %0d", want.height, frame_height);
          fail_count++;
        end
        if (frame_width !== want.width) begin
          $error("frame_width: expected %0d, actual %0d", want.width, frame_width);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    scan_phase = PH_START0;
    bytes_left = '0;
    hi_byte    = '0;
    stray_flag = 1'b0;
    hold_h     = '0;
    hold_w     = '0;
    scan_done  = 1'b1;

    // idle after reset, bad start bytes, end inside the start marker
    add_row(8'hAB,     1'b0, 1'b0, ROW_NONE,    ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h00,     1'b1, 1'b0, ROW_RESULT,  ST_NO_SOI,    16'h0000, 16'h0000);
    add_row(BYTE_FILL, 1'b1, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h00,     1'b0, 1'b0, ROW_RESULT,  ST_NO_SOI,    16'h0000, 16'h0000);
    add_row(BYTE_FILL, 1'b1, 1'b1, ROW_RESULT,  ST_NO_SOI,    16'h0000, 16'h0000);
    // stray byte ahead of a marker
    add_row(BYTE_FILL, 1'b1, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(BYTE_SOI,  1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h37,     1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(BYTE_FILL, 1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(BYTE_EOI,  1'b0, 1'b0, ROW_RESULT,  ST_STRAY,     16'h0000, 16'h0000);
    // scan start before any frame header
    add_row(BYTE_FILL, 1'b1, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(BYTE_SOI,  1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(BYTE_FILL, 1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(BYTE_SOS,  1'b0, 1'b0, ROW_RESULT,  ST_NO_FRAME,  16'h0000, 16'h0000);
    // marker code zero with a length of one
    add_row(BYTE_FILL, 1'b1, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(BYTE_SOI,  1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(BYTE_FILL, 1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h00,     1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h00,     1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h01,     1'b0, 1'b0, ROW_RESULT,  ST_BAD_LEN,   16'h0000, 16'h0000);
    // frame header with fill, extreme sizes, last flag on its final byte
    add_row(BYTE_FILL, 1'b1, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(BYTE_SOI,  1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(BYTE_FILL, 1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(BYTE_FILL, 1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'hCF,     1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h00,     1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h11,     1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h08,     1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'hFF,     1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'hFF,     1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h00,     1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h00,     1'b0, 1'b0, ROW_PREDICT, ST_FOUND,     16'h0000, 16'h0000);
    add_row(8'h03,     1'b0, 1'b1, ROW_RESULT,  ST_FOUND,     16'hFFFF, 16'h0000);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) push_beat(dir_rows[i].b, dir_rows[i].kind, dir_rows[i].res);

    while (sent_beats < BEAT_TARGET) begin
      build_random_file();
      // drop idling for the tail of the run
      if (sent_beats > QUIET_FROM) gaps_on <= 1'b0;
      else gaps_on <= ($urandom_range(0, 3) != 0);
      foreach (file_bytes[i]) push_beat(file_bytes[i], ROW_PREDICT, '0);
    end
    in_valid <= 1'b0;

    while (expected_sizes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
